// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

// ===== src/hmrc_pkg.sv =====
// Shared types, register codes and constants of the heading rotation controller
`default_nettype none

package hmrc_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ANGLE_W   = 16;
    localparam int Z_W       = 26;
    localparam int CUR_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 15;
    localparam int FORCE_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 40;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_RATIO_GAIN  = 2'd0;
    localparam cfg_idx_t REG_VEL_GAIN    = 2'd1;
    localparam cfg_idx_t REG_MAX_ROT_VEL = 2'd2;

    localparam logic [GAIN_W-1:0] RATIO_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] VEL_GAIN_RST    = 16'd256;
    localparam logic [LIM_W-1:0]  MAX_ROT_VEL_RST = 15'd16384;

    // half a turn at 2^24 units per turn
    localparam logic [Z_W-1:0] HALF_TURN = 26'd8388608;

    // atan(2^-i) at 2^24 units per turn, rounded
    localparam logic [23:0] ATAN_TABLE [TABLE_LEN] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
        24'd166669,  24'd83416,   24'd41718,  24'd20860,
        24'd10430,   24'd5215,    24'd2608,   24'd1304,
        24'd652,     24'd326,     24'd163,    24'd81,
        24'd41,      24'd20,      24'd10,     24'd5,
        24'd3,       24'd1,       24'd1,      24'd0
    };

    typedef struct packed {
        logic                    ok;
        logic                    rev;
        logic signed [CUR_W-1:0] cur;
    } side_t;

endpackage

`default_nettype wire

// ===== src/hmrc_cordic.sv =====
// Pipelined vectoring CORDIC giving the heading angle as a 16-bit binary angle
`default_nettype none

`include "assert_macros.svh"

module hmrc_cordic #(
    parameter int VEL_BITS     = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic signed [VEL_BITS-1:0]           vel_x,
    input  wire logic signed [VEL_BITS-1:0]           vel_y,
    input  wire hmrc_pkg::side_t                      in_side,
    output logic                                      out_valid,
    output logic signed [hmrc_pkg::ANGLE_W-1:0]       angle,
    output hmrc_pkg::side_t                           out_side
);

    localparam int STEPS = (CORDIC_STEPS < hmrc_pkg::TABLE_LEN) ?
                           CORDIC_STEPS : hmrc_pkg::TABLE_LEN;
    localparam int XW    = VEL_BITS + 3;
    localparam int ZW    = hmrc_pkg::Z_W;

    logic [STEPS:0]              valid_reg;
    logic signed [XW-1:0]        x_reg    [0:STEPS];
    logic signed [XW-1:0]        y_reg    [0:STEPS];
    logic signed [ZW-1:0]        z_reg    [0:STEPS];
    logic                        zero_reg [0:STEPS];
    hmrc_pkg::side_t             side_reg [0:STEPS];

    logic signed [XW-1:0]        x_ext;
    logic signed [XW-1:0]        y_ext;
    logic                        fold;
    logic signed [ZW-1:0]        z_round;

    assign x_ext = XW'(vel_x);
    assign y_ext = XW'(vel_y);
    assign fold  = vel_x[VEL_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
        end
    end

    // fold the left half plane by half a turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= fold ? -x_ext : x_ext;
            y_reg[0]    <= fold ? -y_ext : y_ext;
            z_reg[0]    <= fold ? $signed(hmrc_pkg::HALF_TURN) : '0;
            zero_reg[0] <= (vel_x == '0) && (vel_y == '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] ATAN_I = ZW'(hmrc_pkg::ATAN_TABLE[i]);

        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic                 y_pos;

        assign dx    = y_reg[i] >>> i;
        assign dy    = x_reg[i] >>> i;
        assign y_pos = !y_reg[i][XW-1] && (y_reg[i] != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= y_pos ? x_reg[i] + dx : x_reg[i] - dx;
                y_reg[i+1]    <= y_pos ? y_reg[i] - dy : y_reg[i] + dy;
                z_reg[i+1]    <= y_pos ? z_reg[i] + ATAN_I : z_reg[i] - ATAN_I;
                zero_reg[i+1] <= zero_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    // round to 65536 units per turn, wrap by truncation
    assign z_round   = z_reg[STEPS] + ZW'(128);
    assign angle     = zero_reg[STEPS] ? '0 : z_round[23:8];
    assign out_valid = valid_reg[STEPS];
    assign out_side  = side_reg[STEPS];

    `ASSERT_ALWAYS(a_cordic_x_nonneg, clk, rst_n,
        valid_reg[STEPS] && !zero_reg[STEPS] |-> !x_reg[STEPS][XW-1])
    `ASSERT_NEVER(a_cordic_zero_angle, clk, rst_n,
        valid_reg[STEPS] && zero_reg[STEPS] && (angle != '0))

endmodule

`default_nettype wire

// ===== src/hmrc_gain.sv =====
// Gain, clamp, velocity loop and saturation stages after the heading angle
`default_nettype none

`include "assert_macros.svh"

module hmrc_gain (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic signed [hmrc_pkg::ANGLE_W-1:0]  angle,
    input  wire hmrc_pkg::side_t                      in_side,
    input  wire logic [hmrc_pkg::GAIN_W-1:0]          ratio_gain,
    input  wire logic [hmrc_pkg::GAIN_W-1:0]          vel_gain,
    input  wire logic [hmrc_pkg::LIM_W-1:0]           max_rot_vel,
    output logic                                      out_valid,
    output logic signed [hmrc_pkg::FORCE_W-1:0]       force_res,
    output logic                                      ok
);

    localparam int P1_W  = hmrc_pkg::ANGLE_W + hmrc_pkg::GAIN_W + 1;
    localparam int ERR_W = hmrc_pkg::CUR_W + 2;
    localparam int P2_W  = ERR_W + hmrc_pkg::GAIN_W + 1;

    localparam logic signed [P2_W-1:0] F_MAX = P2_W'(64'sd2147483647);
    localparam logic signed [P2_W-1:0] F_MIN = -P2_W'(64'sd2147483648);

    logic [3:0]                       valid_reg;
    logic signed [P1_W-1:0]           prod1_reg;
    hmrc_pkg::side_t                  side_a_reg;
    logic signed [ERR_W-1:0]          err_reg;
    logic                             ok_b_reg;
    logic signed [P2_W-1:0]           prod2_reg;
    logic                             ok_c_reg;
    logic signed [hmrc_pkg::FORCE_W-1:0] force_reg;
    logic                             ok_d_reg;

    logic signed [hmrc_pkg::ANGLE_W-1:0] angle_dir;
    logic signed [P1_W-1:0]           prod1_next;
    logic signed [P1_W-1:0]           des_full;
    logic signed [P1_W-1:0]           lim_pos;
    logic signed [P1_W-1:0]           des_sel;
    logic signed [ERR_W-1:0]          err_next;
    logic signed [P2_W-1:0]           prod2_next;
    logic signed [P2_W-1:0]           f_full;
    logic signed [hmrc_pkg::FORCE_W-1:0] force_next;

    // half a turn back in reverse: flip the top bit of the binary angle
    assign angle_dir  = {angle[hmrc_pkg::ANGLE_W-1] ^ in_side.rev,
                         angle[hmrc_pkg::ANGLE_W-2:0]};
    assign prod1_next = P1_W'(angle_dir) * $signed({1'b0, ratio_gain});

    assign des_full = (prod1_reg + P1_W'(128)) >>> 8;
    assign lim_pos  = $signed(P1_W'(max_rot_vel));

    always_comb
    begin
        des_sel = des_full;
        if (des_full > lim_pos)
        begin
            des_sel = lim_pos;
        end
        if (des_full < -lim_pos)
        begin
            des_sel = -lim_pos;
        end
    end

    assign err_next   = ERR_W'(des_sel) - ERR_W'(side_a_reg.cur);
    assign prod2_next = P2_W'(err_reg) * $signed({1'b0, vel_gain});
    assign f_full     = (prod2_reg + P2_W'(128)) >>> 8;

    always_comb
    begin
        if (!ok_c_reg)
        begin
            force_next = '0;
        end
        else if (f_full > F_MAX)
        begin
            force_next = F_MAX[hmrc_pkg::FORCE_W-1:0];
        end
        else if (f_full < F_MIN)
        begin
            force_next = F_MIN[hmrc_pkg::FORCE_W-1:0];
        end
        else
        begin
            force_next = f_full[hmrc_pkg::FORCE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg  <= prod1_next;
            side_a_reg <= in_side;
            err_reg    <= err_next;
            ok_b_reg   <= side_a_reg.ok;
            prod2_reg  <= prod2_next;
            ok_c_reg   <= ok_b_reg;
            force_reg  <= force_next;
            ok_d_reg   <= ok_c_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign force_res = force_reg;
    assign ok        = ok_d_reg;

    `ASSERT_NEVER(a_gain_zero_when_bad, clk, rst_n,
        valid_reg[3] && !ok_d_reg && (force_reg != '0))
    `ASSERT_ALWAYS(a_gain_err_range, clk, rst_n,
        valid_reg[1] |-> (err_reg <= 18'sd65535) && (err_reg >= -18'sd65535))

endmodule

`default_nettype wire

// ===== src/heading_to_motion_rotation_control.sv =====
// Top level of the heading rotation controller: config registers, stall control, packing
//
// Input items arrive on s_tvalid/s_tready/s_tdata, one velocity sample each.
// Results leave on m_tvalid/m_tready/m_tdata, exactly one per input item, in order.
// Registers are written through cfg_valid/cfg_ready with cfg_index and cfg_data:
// 0 ratio_gain, 1 vel_gain, 2 max_rot_vel; other indexes are ignored.
// cfg_ready is always high; write only while no item is in flight.
// From acceptance to m_tvalid an item passes one input fold stage, one register per
// CORDIC step and four stages for the two gain products, the clamp and the saturation.
// Throughput: one item per cycle while the receiver takes results.
// The last stage is the output register; when it holds a result and m_tready is low,
// the whole pipeline and s_tready hold until the result is taken.
// Reset clears all valid bits and loads the registers with their defaults.
`default_nettype none

module heading_to_motion_rotation_control #(
    parameter int VEL_BITS     = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // vel_x, vel_y, vel_valid, cur_rot_vel, cur_valid, reverse, zero pad
    input  wire logic [((2*VEL_BITS+19+7)/8)*8-1:0]     s_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // force_res, ok, zero pad
    output logic [hmrc_pkg::OUT_W-1:0]                  m_tdata,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire hmrc_pkg::cfg_idx_t                     cfg_index,
    input  wire logic [hmrc_pkg::GAIN_W-1:0]            cfg_data
);

    localparam int VB = VEL_BITS;

    logic [hmrc_pkg::GAIN_W-1:0] ratio_gain_reg;
    logic [hmrc_pkg::GAIN_W-1:0] vel_gain_reg;
    logic [hmrc_pkg::LIM_W-1:0]  max_rot_vel_reg;

    logic                                  en;
    logic                                  in_valid;
    hmrc_pkg::side_t                       in_side;
    logic                                  ang_valid;
    logic signed [hmrc_pkg::ANGLE_W-1:0]   angle;
    hmrc_pkg::side_t                       ang_side;
    logic                                  out_valid;
    logic signed [hmrc_pkg::FORCE_W-1:0]   force_res;
    logic                                  ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_gain_reg  <= hmrc_pkg::RATIO_GAIN_RST;
            vel_gain_reg    <= hmrc_pkg::VEL_GAIN_RST;
            max_rot_vel_reg <= hmrc_pkg::MAX_ROT_VEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hmrc_pkg::REG_RATIO_GAIN:  ratio_gain_reg  <= cfg_data;
                hmrc_pkg::REG_VEL_GAIN:    vel_gain_reg    <= cfg_data;
                hmrc_pkg::REG_MAX_ROT_VEL: max_rot_vel_reg <= cfg_data[hmrc_pkg::LIM_W-1:0];
                default:                   ;
            endcase
        end
    end

    // advance unless a result waits in the output register
    assign en       = !out_valid || m_tready;
    assign s_tready = en;
    assign in_valid = s_tvalid && s_tready;

    assign in_side.ok  = s_tdata[2*VB] && s_tdata[2*VB+17];
    assign in_side.rev = s_tdata[2*VB+18];
    assign in_side.cur = $signed(s_tdata[2*VB+16:2*VB+1]);

    hmrc_cordic #(
        .VEL_BITS     (VEL_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .vel_x     ($signed(s_tdata[VB-1:0])),
        .vel_y     ($signed(s_tdata[2*VB-1:VB])),
        .in_side   (in_side),
        .out_valid (ang_valid),
        .angle     (angle),
        .out_side  (ang_side)
    );

    hmrc_gain u_gain (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (ang_valid),
        .angle       (angle),
        .in_side     (ang_side),
        .ratio_gain  (ratio_gain_reg),
        .vel_gain    (vel_gain_reg),
        .max_rot_vel (max_rot_vel_reg),
        .out_valid   (out_valid),
        .force_res   (force_res),
        .ok          (ok)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'b0, ok, force_res};

endmodule

`default_nettype wire
